FILE: rtl/erdf_pkg.sv
// ----------------------------------------------------------------------------
// erdf_pkg
// Types and codes shared by the receive dispatch filter modules.
// ----------------------------------------------------------------------------
package erdf_pkg;

  typedef enum logic [1:0] {
    K_SET   = 2'd0,
    K_FRAME = 2'd1,
    K_TAKE  = 2'd2,
    K_CLOSE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_TAKEN     = 3'd2,
    ST_NONE      = 3'd3,
    ST_DONE      = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  localparam logic [1:0] MODE_SHARED = 2'd1;
  localparam logic [1:0] MODE_COPY   = 2'd2;

  localparam logic [3:0] CLS_LOC     = 4'b0001;
  localparam logic [3:0] CLS_BROAD   = 4'b0010;
  localparam logic [3:0] CLS_MULTI   = 4'b0100;
  localparam logic [3:0] CLS_PROMISC = 4'b1000;

  localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  listener;
    logic [47:0] dest_addr;
    logic [47:0] src_addr;
    logic [15:0] ether_type;
    logic [3:0]  class_mask;
    logic        type_match_on;
    logic        remote_match_on;
    logic [1:0]  access_mode;
  } in_item_t;

  typedef struct packed {
    logic [4:0] target;
    logic [2:0] status;
    logic [3:0] pending_now;
    logic       last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  listener;
    logic [47:0] src_addr;
    logic [15:0] ether_type;
    logic [3:0]  cls;
    logic [3:0]  class_mask;
    logic        type_match_on;
    logic        remote_match_on;
    logic [1:0]  access_mode;
  } cmd_t;

endpackage

FILE: rtl/erdf_fifo.sv
// ----------------------------------------------------------------------------
// erdf_fifo
// Short register queue with full/empty flags.
// ----------------------------------------------------------------------------
module erdf_fifo import erdf_pkg::*; #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  T                mem [QDEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/erdf_front.sv
// ----------------------------------------------------------------------------
// erdf_front
// Input stage: holds station address, takes items and classifies frames.
// ----------------------------------------------------------------------------
module erdf_front import erdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic [47:0] cfg_wdata,
  input  logic     in_push,
  input  in_item_t in_data,
  output logic     in_full,
  output logic     cmd_push,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  logic [47:0] station_r;
  in_item_t    item_r;
  logic        valid_r;
  logic        take;
  logic [3:0]  cls;

  assign cmd_push = valid_r;
  assign in_full  = valid_r && cmd_full;
  assign take     = in_push && !in_full;

  always_comb begin
    if (item_r.dest_addr[0]) begin
      cls = (item_r.dest_addr == BCAST_ADDR) ? CLS_BROAD : CLS_MULTI;
    end else begin
      cls = (item_r.dest_addr == station_r) ? CLS_LOC : CLS_PROMISC;
    end
    cmd.kind            = kind_t'(item_r.kind);
    cmd.listener        = item_r.listener;
    cmd.src_addr        = item_r.src_addr;
    cmd.ether_type      = item_r.ether_type;
    cmd.cls             = cls;
    // promiscuous also takes broadcast and multicast
    cmd.class_mask      = item_r.class_mask |
                          (item_r.class_mask[3] ? (CLS_PROMISC | CLS_MULTI | CLS_BROAD) : 4'b0);
    cmd.type_match_on   = item_r.type_match_on;
    cmd.remote_match_on = item_r.remote_match_on;
    cmd.access_mode     = item_r.access_mode;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        station_r <= cfg_wdata;
      end
      if (take) begin
        valid_r <= 1'b1;
      end else if (!cmd_full) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/erdf_back.sv
// ----------------------------------------------------------------------------
// erdf_back
// Listener table and dispatch sequencer: one table entry per cycle while results are not stalled.
// ----------------------------------------------------------------------------
module erdf_back import erdf_pkg::*; #(
  parameter int LISTENERS   = 32,
  parameter int PENDING_MAX = 15
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);

  localparam int IW = (LISTENERS > 1) ? $clog2(LISTENERS) : 1;
  localparam int PW = $clog2(PENDING_MAX + 1);

  typedef enum logic [1:0] {B_IDLE, B_WALK, B_SHARE, B_FIN} bstate_t;

  bstate_t        state_r;
  logic           active_r [LISTENERS];
  logic [PW-1:0]  pend_r   [LISTENERS];
  logic [3:0]     acc_r    [LISTENERS];
  logic           tchk_r   [LISTENERS];
  logic           rchk_r   [LISTENERS];
  logic [1:0]     mode_r   [LISTENERS];
  logic [15:0]    wtype_r  [LISTENERS];
  logic [47:0]    wrem_r   [LISTENERS];

  cmd_t           cur_r;
  logic [IW-1:0]  walk_r, share_r;
  logic           have_share_r;
  out_item_t      hold_r;
  logic           hold_v_r;

  logic [IW-1:0]  rd_idx, cidx;
  logic           in_range, match, aside, emit_ok, opt_we;
  logic [PW-1:0]  pend_rd, pend_new;
  logic           ovf;
  out_item_t      dres;

  assign cidx     = IW'(cmd.listener);
  assign in_range = ({4'b0, cmd.listener} < 9'(LISTENERS));
  assign rd_idx   = (state_r == B_IDLE) ? cidx : (state_r == B_SHARE) ? share_r : walk_r;
  assign pend_rd  = pend_r[rd_idx];
  assign match    = active_r[rd_idx] && |(acc_r[rd_idx] & cur_r.cls) &&
                    (!tchk_r[rd_idx] || cur_r.ether_type == wtype_r[rd_idx]) &&
                    (!rchk_r[rd_idx] || cur_r.src_addr == wrem_r[rd_idx]);
  assign aside    = (pend_rd != '0) && (mode_r[rd_idx] == MODE_SHARED);
  assign ovf      = (pend_rd >= PW'(PENDING_MAX));
  assign pend_new = ovf ? pend_rd : pend_rd + 1'b1;
  assign emit_ok  = !hold_v_r || !res_full;
  assign opt_we   = (state_r == B_IDLE) && cmd_valid && (cmd.kind == K_SET) && in_range;

  always_comb begin
    dres.target      = 5'(rd_idx);
    dres.status      = ovf ? ST_OVERFLOW : ST_DELIVERED;
    dres.pending_now = 4'(pend_new);
    dres.last        = 1'b0;
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res      = hold_r;
    unique case (state_r)
      B_IDLE:  cmd_pop = cmd_valid;
      B_WALK:  res_push = hold_v_r && match && !aside;
      B_SHARE: res_push = hold_v_r && have_share_r;
      B_FIN: begin
        res_push = 1'b1;
        if (hold_v_r) begin
          res.last = 1'b1;
        end else begin
          res = '{target: 5'd0, status: ST_DROPPED, pending_now: 4'd0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  // options carry no reset; read only once a listener is open
  always_ff @(posedge clk) begin
    if (opt_we) begin
      acc_r[cidx]   <= cmd.class_mask;
      tchk_r[cidx]  <= cmd.type_match_on;
      rchk_r[cidx]  <= cmd.remote_match_on;
      mode_r[cidx]  <= cmd.access_mode;
      wtype_r[cidx] <= cmd.ether_type;
      wrem_r[cidx]  <= cmd.src_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      hold_v_r <= 1'b0;
      for (int i = 0; i < LISTENERS; i++) begin
        active_r[i] <= 1'b0;
        pend_r[i]   <= '0;
      end
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (cmd_valid) begin
            cur_r <= cmd;
            unique case (cmd.kind)
              K_SET: begin
                hold_v_r <= 1'b1;
                state_r  <= B_FIN;
                if (in_range) begin
                  active_r[cidx] <= 1'b1;
                  pend_r[cidx]   <= '0;
                  hold_r <= '{target: cmd.listener, status: ST_DONE, pending_now: 4'd0,
                              last: 1'b1};
                end else begin
                  hold_r <= '{target: cmd.listener, status: ST_DROPPED, pending_now: 4'd0,
                              last: 1'b1};
                end
              end
              K_CLOSE: begin
                hold_v_r <= 1'b1;
                state_r  <= B_FIN;
                if (in_range) begin
                  active_r[cidx] <= 1'b0;
                  pend_r[cidx]   <= '0;
                  hold_r <= '{target: cmd.listener, status: ST_DONE, pending_now: 4'd0,
                              last: 1'b1};
                end else begin
                  hold_r <= '{target: cmd.listener, status: ST_DROPPED, pending_now: 4'd0,
                              last: 1'b1};
                end
              end
              K_TAKE: begin
                hold_v_r <= 1'b1;
                state_r  <= B_FIN;
                if (in_range && pend_rd != '0) begin
                  pend_r[cidx] <= pend_rd - 1'b1;
                  hold_r <= '{target: cmd.listener, status: ST_TAKEN,
                              pending_now: 4'(pend_rd - 1'b1), last: 1'b1};
                end else begin
                  hold_r <= '{target: cmd.listener, status: ST_NONE, pending_now: 4'd0,
                              last: 1'b1};
                end
              end
              K_FRAME: begin
                walk_r       <= '0;
                have_share_r <= 1'b0;
                state_r      <= B_WALK;
              end
              default: ;
            endcase
          end
        end
        B_WALK: begin
          if (match && aside) begin
            have_share_r <= 1'b1;
            share_r      <= walk_r;
          end
          if (!(match && !aside) || emit_ok) begin
            if (match && !aside) begin
              pend_r[walk_r] <= pend_new;
              hold_r         <= dres;
              hold_v_r       <= 1'b1;
            end
            if (match && !aside && mode_r[walk_r] != MODE_COPY) begin
              state_r <= B_FIN;
            end else if (walk_r == IW'(LISTENERS - 1)) begin
              state_r <= B_SHARE;
            end else begin
              walk_r <= walk_r + 1'b1;
            end
          end
        end
        B_SHARE: begin
          if (!have_share_r) begin
            state_r <= B_FIN;
          end else if (emit_ok) begin
            pend_r[share_r] <= pend_new;
            hold_r          <= dres;
            hold_v_r        <= 1'b1;
            state_r         <= B_FIN;
          end
        end
        B_FIN: begin
          if (!res_full) begin
            hold_v_r <= 1'b0;
            state_r  <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ethernet_receive_dispatch_filter_core.sv
// ----------------------------------------------------------------------------
// ethernet_receive_dispatch_filter_core
// Receive listener table with in-order frame dispatch.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port (push/full) and results leave through
// another (empty/pop). A frame header walks the listener table one entry per
// cycle in the dispatch sequencer while the result side does not stall; the
// walk stops early on an exclusive or shared delivery.
// The front stage classifies the next item while the walk runs; a two-entry
// command queue and a two-entry result queue decouple the sides, so output
// stalls back-pressure the walk only once both result slots are taken.
// The station address is written through cfg_we/cfg_wdata; the user must
// write it only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ethernet_receive_dispatch_filter_core import erdf_pkg::*; #(
  parameter int LISTENERS   = 32,
  parameter int PENDING_MAX = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata,
  input  logic        in_push,
  input  in_item_t    in_data,
  output logic        full,
  input  logic        pop,
  output out_item_t   out_data,
  output logic        empty
);

  // front to command queue
  logic      f_push, f_full;
  cmd_t      f_cmd;
  // command queue to sequencer
  logic      c_empty, c_pop;
  cmd_t      c_cmd;
  // sequencer to result queue
  logic      r_push, r_full;
  out_item_t r_res;

  erdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (full),
    .cmd_push (f_push),
    .cmd      (f_cmd),
    .cmd_full (f_full)
  );

  erdf_fifo #(.T(cmd_t)) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_push),
    .wdata(f_cmd),
    .full (f_full),
    .pop  (c_pop),
    .rdata(c_cmd),
    .empty(c_empty)
  );

  erdf_back #(
    .LISTENERS  (LISTENERS),
    .PENDING_MAX(PENDING_MAX)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(!c_empty),
    .cmd      (c_cmd),
    .cmd_pop  (c_pop),
    .res_push (r_push),
    .res      (r_res),
    .res_full (r_full)
  );

  // result queue: oldest result shown while not empty
  erdf_fifo #(.T(out_item_t)) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (r_push),
    .wdata(r_res),
    .full (r_full),
    .pop  (pop),
    .rdata(out_data),
    .empty(empty)
  );

endmodule

FILE: rtl/erdf_checker.sv
// ----------------------------------------------------------------------------
// erdf_checker
// Port-level checks on the dispatch filter result channel.
// ----------------------------------------------------------------------------
module erdf_checker import erdf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not clear after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("waiting result changed");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.status == ST_DROPPED |-> out_data.pending_now == 4'd0 && out_data.last)
    else $error("dropped result malformed");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_data.status == ST_TAKEN || out_data.status == ST_NONE ||
               out_data.status == ST_DONE) |-> out_data.last)
    else $error("single-result item without last");

endmodule

bind ethernet_receive_dispatch_filter_core erdf_checker u_erdf_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);
